/* rtl/tlh_pkg.sv */
// Shared types and constants for the thresholded lag histogram block.
// Depends on nothing; imported by the top level.
package tlh_pkg;

	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int OPCODE_W = 2;
	localparam int COUNT_W  = 16;
	localparam int PILE_W   = 4;
	localparam int LAG_W    = 14;

	typedef logic [CFG_W-1:0] cfg_word_t;

	localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ_BIN  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ_PEAK = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LAG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_HIGH  = 2'd2;

	localparam cfg_word_t LAG_WINDOW_RST = 13'd3000;
	localparam cfg_word_t PEAK_LOW_RST   = 13'd110;
	localparam cfg_word_t PEAK_HIGH_RST  = 13'd190;

endpackage

/* rtl/tlh_sat_update.sv */
// Saturating per-pile bin update of one wide histogram word.
// Depends on nothing; used by the top level for each histogram memory.
module tlh_sat_update #(
	parameter int PILES     = 10,
	parameter int BIN_WIDTH = 31
) (
	input  logic [PILES*BIN_WIDTH-1:0] word,
	input  logic [PILES-1:0]           hit_a,
	input  logic [PILES-1:0]           hit_b,
	output logic [PILES*BIN_WIDTH-1:0] updated
);

	always_comb begin
		logic [BIN_WIDTH:0] sum;
		for (int p = 0; p < PILES; p++) begin
			sum = {1'b0, word[p*BIN_WIDTH +: BIN_WIDTH]}
				+ (BIN_WIDTH+1)'(hit_a[p]) + (BIN_WIDTH+1)'(hit_b[p]);
			// clamp at all ones
			updated[p*BIN_WIDTH +: BIN_WIDTH] = sum[BIN_WIDTH] ? {BIN_WIDTH{1'b1}}
				: sum[BIN_WIDTH-1:0];
		end
	end

endmodule

/* rtl/thresholded_lag_histogram_top.sv */
// Top level of the thresholded lag histogram (phasogram and distogram).
// Depends on tlh_pkg and tlh_sat_update.
//
//  channel | direction | beat contents
//  in      | sink      | opcode, fwd_count, rev_count, plot_select, pile_index, lag
//  out     | source    | read_value, status
//  cfg     | sink      | cfg_we, cfg_index, cfg_data (write only)
//
// A position sample reads and writes back each lag from 0 up to the window in turn:
// one memory read-modify-write per lag, all piles of one lag in one word of each memory.
// A bin read passes through S_RD1 and S_RD2; a peak search steps through the lags from
// peak_low to peak_high-1 in S_PK, then S_PKF. The next beat in is taken after S_RES.
// After reset a clearing pass zeroes all memories; in_stall
// stays high until it ends. A waiting result does not block the next beat in.
module thresholded_lag_histogram_top #(
	parameter int MAX_LAG   = 4096,
	parameter int PILES     = 10,
	parameter int BIN_WIDTH = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tlh_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tlh_pkg::COUNT_W-1:0]   fwd_count,
	input  logic [tlh_pkg::COUNT_W-1:0]   rev_count,
	input  logic                          plot_select,
	input  logic [tlh_pkg::PILE_W-1:0]    pile_index,
	input  logic signed [tlh_pkg::LAG_W-1:0] lag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [BIN_WIDTH-1:0]          read_value,
	output logic                          status,
	input  logic                          cfg_we,
	input  logic [tlh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlh_pkg::CFG_W-1:0]     cfg_data
);
	import tlh_pkg::*;

	localparam int DW     = $clog2(MAX_LAG + 1);
	localparam int HW     = $clog2(MAX_LAG);
	localparam int WW     = PILES * BIN_WIDTH;
	localparam int PIDX_W = (PILES > 1) ? $clog2(PILES) : 1;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SAMP = 4'd2;
	localparam logic [3:0] S_SFIN = 4'd3;
	localparam logic [3:0] S_RD1  = 4'd4;
	localparam logic [3:0] S_RD2  = 4'd5;
	localparam logic [3:0] S_PK   = 4'd6;
	localparam logic [3:0] S_PKF  = 4'd7;
	localparam logic [3:0] S_RES  = 4'd8;

	localparam logic [1:0] SEL_PHASO = 2'd0;
	localparam logic [1:0] SEL_NEG   = 2'd1;
	localparam logic [1:0] SEL_POS   = 2'd2;

	// memories
	logic [WW-1:0]        phaso_mem [MAX_LAG+1];
	logic [WW-1:0]        neg_mem   [MAX_LAG+1];
	logic [WW-1:0]        pos_mem   [MAX_LAG+1];
	logic [2*PILES-1:0]   hist_mem  [MAX_LAG];

	logic [WW-1:0]        phaso_rd_q, neg_rd_q, pos_rd_q;
	logic [2*PILES-1:0]   hist_rd_q;

	cfg_word_t            lag_window_q, peak_low_q, peak_high_q;
	logic [3:0]           state_q;
	logic [DW-1:0]        clr_q, d_q, d_s1, rd_addr_q, best_lag_q;
	logic [HW-1:0]        head_q;
	logic [PILES-1:0]     mf_q, mr_q;
	logic [PIDX_W-1:0]    pidx_q;
	logic [1:0]           rsel_q;
	logic [BIN_WIDTH-1:0] best_q;
	logic                 samp_v_s1, pk_v_s1, pk_first_s1;
	logic [BIN_WIDTH-1:0] res_value_q;
	logic                 res_status_q;
	logic                 out_valid_q;
	logic [BIN_WIDTH-1:0] read_value_q;
	logic                 status_q;

	logic [DW-1:0]        win, raddr;
	logic [HW-1:0]        slot;
	logic [31:0]          slot_sum;
	logic [PILES-1:0]     mf_n, mr_n, pf, pr;
	logic [WW-1:0]        phaso_upd, neg_upd, pos_upd;
	logic                 accept, clr_we, hist_clr_we;
	logic signed [31:0]   lag_x, win_s, mag;
	logic                 pile_bad, peak_bad, bin_bad;
	logic [BIN_WIDTH-1:0] pk_b, rd_lane;
	logic                 pk_take;
	logic [DW-1:0]        pk_lag_n;

	assign win = (32'(lag_window_q) > 32'(MAX_LAG)) ? DW'(MAX_LAG) : DW'(lag_window_q);
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign read_value = read_value_q;
	assign status = status_q;

	always_comb begin
		for (int k = 0; k < PILES; k++) begin
			mf_n[k] = (32'(fwd_count) >= 32'(k + 1));
			mr_n[k] = (32'(rev_count) >= 32'(k + 1));
		end
	end

	// request checks
	assign lag_x = 32'(lag);
	assign win_s = 32'(win);
	assign mag   = (lag_x < 0) ? -lag_x : lag_x;
	assign pile_bad = (pile_index == '0) || (32'(pile_index) > 32'(PILES));
	assign peak_bad = (32'(peak_high_q) > 32'(win) + 32'd1) || (peak_low_q >= peak_high_q);
	assign bin_bad  = plot_select ? (lag_x < -win_s || lag_x > win_s)
		: (lag_x < 0 || lag_x > win_s);

	// history slot for lag d
	assign slot_sum = 32'(head_q) + 32'(MAX_LAG) - 32'(d_q);
	assign slot = (slot_sum >= 32'(MAX_LAG)) ? HW'(slot_sum - 32'(MAX_LAG)) : HW'(slot_sum);

	always_comb begin
		case (state_q)
			S_SAMP:  raddr = d_q;
			S_RD1:   raddr = rd_addr_q;
			S_PK:    raddr = rd_addr_q;
			default: raddr = d_q;
		endcase
	end

	// lag zero pairs the new marks with themselves
	assign pf = (d_s1 == '0) ? mf_q : hist_rd_q[PILES-1:0];
	assign pr = (d_s1 == '0) ? mr_q : hist_rd_q[2*PILES-1:PILES];

	tlh_sat_update #(.PILES(PILES), .BIN_WIDTH(BIN_WIDTH)) u_upd_phaso (
		.word(phaso_rd_q), .hit_a(mf_q & pf), .hit_b(mr_q & pr), .updated(phaso_upd)
	);
	tlh_sat_update #(.PILES(PILES), .BIN_WIDTH(BIN_WIDTH)) u_upd_neg (
		.word(neg_rd_q), .hit_a(mf_q & pr), .hit_b('0), .updated(neg_upd)
	);
	tlh_sat_update #(.PILES(PILES), .BIN_WIDTH(BIN_WIDTH)) u_upd_pos (
		.word(pos_rd_q), .hit_a(pf & mr_q), .hit_b('0), .updated(pos_upd)
	);

	assign clr_we = (state_q == S_CLR);
	assign hist_clr_we = clr_we && (32'(clr_q) < 32'(MAX_LAG));

	always_ff @(posedge clk) begin
		phaso_rd_q <= phaso_mem[raddr];
		neg_rd_q   <= neg_mem[raddr];
		pos_rd_q   <= pos_mem[raddr];
		hist_rd_q  <= hist_mem[slot];
		if (clr_we) begin
			phaso_mem[clr_q] <= '0;
			neg_mem[clr_q]   <= '0;
			pos_mem[clr_q]   <= '0;
		end else if (samp_v_s1) begin
			phaso_mem[d_s1] <= phaso_upd;
			neg_mem[d_s1]   <= neg_upd;
			if (d_s1 != '0) begin
				pos_mem[d_s1] <= pos_upd;
			end
		end
		if (hist_clr_we) begin
			hist_mem[HW'(clr_q)] <= '0;
		end else if (state_q == S_SFIN) begin
			hist_mem[head_q] <= {mr_q, mf_q};
		end
	end

	// peak search compare stage
	assign pk_b = (d_s1 == '0) ? neg_rd_q[pidx_q*BIN_WIDTH +: BIN_WIDTH]
		: pos_rd_q[pidx_q*BIN_WIDTH +: BIN_WIDTH];
	assign pk_take = pk_v_s1 && (pk_first_s1 || pk_b > best_q);
	assign pk_lag_n = pk_take ? d_s1 : best_lag_q;

	always_comb begin
		case (rsel_q)
			SEL_PHASO: rd_lane = phaso_rd_q[pidx_q*BIN_WIDTH +: BIN_WIDTH];
			SEL_NEG:   rd_lane = neg_rd_q[pidx_q*BIN_WIDTH +: BIN_WIDTH];
			SEL_POS:   rd_lane = pos_rd_q[pidx_q*BIN_WIDTH +: BIN_WIDTH];
			default:   rd_lane = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_window_q <= LAG_WINDOW_RST;
			peak_low_q   <= PEAK_LOW_RST;
			peak_high_q  <= PEAK_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAG_WINDOW: lag_window_q <= cfg_data;
				REG_PEAK_LOW:   peak_low_q   <= cfg_data;
				REG_PEAK_HIGH:  peak_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			head_q      <= '0;
			samp_v_s1   <= 1'b0;
			pk_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			samp_v_s1 <= 1'b0;
			pk_v_s1   <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pk_take) begin
				best_q     <= pk_b;
				best_lag_q <= d_s1;
			end
			case (state_q)
				S_CLR: begin
					if (32'(clr_q) == 32'(MAX_LAG)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						res_value_q  <= '0;
						res_status_q <= 1'b0;
						mf_q         <= mf_n;
						mr_q         <= mr_n;
						pidx_q       <= PIDX_W'(pile_index - 1'b1);
						d_q          <= '0;
						rd_addr_q    <= DW'(peak_low_q);
						state_q      <= S_RES;
						if (opcode == OP_SAMPLE) begin
							state_q <= S_SAMP;
						end else if (opcode == OP_READ_BIN) begin
							if (pile_bad || bin_bad) begin
								res_status_q <= 1'b1;
							end else begin
								rd_addr_q <= DW'(mag);
								state_q   <= S_RD1;
								if (!plot_select) begin
									rsel_q <= SEL_PHASO;
								end else if (lag_x > 0) begin
									rsel_q <= SEL_POS;
								end else begin
									rsel_q <= SEL_NEG;
								end
							end
						end else if (opcode == OP_READ_PEAK) begin
							if (pile_bad || peak_bad) begin
								res_status_q <= 1'b1;
							end else begin
								state_q <= S_PK;
							end
						end
					end
				end
				S_SAMP: begin
					samp_v_s1 <= 1'b1;
					d_s1      <= d_q;
					if (d_q == win) begin
						state_q <= S_SFIN;
					end
					d_q <= d_q + 1'b1;
				end
				S_SFIN: begin
					// last lag is written back this cycle; store the new marks
					head_q  <= (32'(head_q) == 32'(MAX_LAG - 1)) ? '0 : head_q + 1'b1;
					state_q <= S_RES;
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					res_value_q <= rd_lane;
					state_q     <= S_RES;
				end
				S_PK: begin
					pk_v_s1     <= 1'b1;
					pk_first_s1 <= (32'(rd_addr_q) == 32'(peak_low_q));
					d_s1        <= rd_addr_q;
					if (32'(rd_addr_q) + 32'd1 == 32'(peak_high_q)) begin
						state_q <= S_PKF;
					end
					rd_addr_q <= rd_addr_q + 1'b1;
				end
				S_PKF: begin
					res_value_q <= BIN_WIDTH'(pk_lag_n);
					state_q     <= S_RES;
				end
				S_RES: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						read_value_q <= res_value_q;
						status_q     <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/tlh_checker.sv */
// Port-level assertions for the thresholded lag histogram top level.
// Depends on thresholded_lag_histogram_top; attached by the bind below.
module tlh_checker #(
	parameter int BIN_WIDTH = 31
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [BIN_WIDTH-1:0] read_value,
	input logic                 status
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled result beat changed");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_value == '0)
		else $error("error beat carries a value");

endmodule

bind thresholded_lag_histogram_top tlh_checker #(.BIN_WIDTH(BIN_WIDTH)) u_tlh_checker (.*);

/* tb/tb_thresholded_lag_histogram_checker.sv */
// Checker for the thresholded lag histogram: watches the in, out and cfg ports,
// predicts each result and compares it. Depends on tlh_pkg.
module tb_thresholded_lag_histogram_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tlh_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tlh_pkg::COUNT_W-1:0]   fwd_count,
	input  logic [tlh_pkg::COUNT_W-1:0]   rev_count,
	input  logic                          plot_select,
	input  logic [tlh_pkg::PILE_W-1:0]    pile_index,
	input  logic signed [tlh_pkg::LAG_W-1:0] lag,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [30:0]                   read_value,
	input  logic                          status,
	input  logic                          cfg_we,
	input  logic [tlh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlh_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlh_pkg::*;

	localparam int MAXL = 4096;
	localparam int NPILE = 10;
	localparam logic [30:0] SAT = 31'h7FFFFFFF;

	typedef struct packed {
		logic [30:0] value;
		logic        st;
	} answer_t;

	cfg_word_t   win_reg, plow_reg, phigh_reg;
	logic [30:0] phaso [NPILE][MAXL+1];
	logic [30:0] disto [NPILE][2*MAXL+1];
	logic [9:0]  fwd_hist [MAXL];
	logic [9:0]  rev_hist [MAXL];
	logic [11:0] head;
	answer_t     answers[$];

	assign pending = answers.size();

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	function automatic int eff_window();
		return (win_reg > MAXL) ? MAXL : int'(win_reg);
	endfunction

	function automatic logic [9:0] thresholds(input logic [15:0] cnt);
		logic [9:0] m;
		m = '0;
		for (int k = 1; k <= NPILE; k++)
			if (cnt >= k) m[k-1] = 1'b1;
		return m;
	endfunction

	task automatic bump_phaso(input logic [9:0] hits, input int idx);
		for (int p = 0; p < NPILE; p++)
			if (hits[p] && phaso[p][idx] != SAT) phaso[p][idx]++;
	endtask

	task automatic bump_disto(input logic [9:0] hits, input int idx);
		for (int p = 0; p < NPILE; p++)
			if (hits[p] && disto[p][idx] != SAT) disto[p][idx]++;
	endtask

	task automatic add_position(input logic [15:0] f, input logic [15:0] r);
		logic [9:0]  mf, mr, pf, pr;
		logic [11:0] slot;
		int          w;
		mf = thresholds(f);
		mr = thresholds(r);
		w = eff_window();
		bump_phaso(mf, 0);
		bump_phaso(mr, 0);
		bump_disto(mf & mr, MAXL);
		for (int d = 1; d <= w; d++) begin
			slot = head - 12'(d);
			pf = fwd_hist[slot];
			pr = rev_hist[slot];
			bump_phaso(mf & pf, d);
			bump_phaso(mr & pr, d);
			bump_disto(mf & pr, MAXL - d);
			bump_disto(pf & mr, MAXL + d);
		end
		fwd_hist[head] = mf;
		rev_hist[head] = mr;
		head++;
	endtask

	function automatic answer_t predict_beat();
		answer_t a;
		int      w, lg, best_lag;
		logic [30:0] best;
		a = '0;
		w = eff_window();
		lg = int'(lag);
		if (opcode == OP_READ_BIN || opcode == OP_READ_PEAK) begin
			if (pile_index < 1 || pile_index > NPILE) begin
				a.st = 1'b1;
			end else if (opcode == OP_READ_BIN) begin
				if (!plot_select) begin
					if (lg < 0 || lg > w) a.st = 1'b1;
					else a.value = phaso[pile_index-1][lg];
				end else begin
					if (lg < -w || lg > w) a.st = 1'b1;
					else a.value = disto[pile_index-1][lg + MAXL];
				end
			end else begin
				if (int'(phigh_reg) > w + 1 || plow_reg >= phigh_reg) begin
					a.st = 1'b1;
				end else begin
					best_lag = plow_reg;
					best = disto[pile_index-1][MAXL + plow_reg];
					for (int i = plow_reg + 1; i < phigh_reg; i++)
						if (disto[pile_index-1][MAXL + i] > best) begin
							best = disto[pile_index-1][MAXL + i];
							best_lag = i;
						end
					a.value = 31'(best_lag);
				end
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			win_reg <= LAG_WINDOW_RST;
			plow_reg <= PEAK_LOW_RST;
			phigh_reg <= PEAK_HIGH_RST;
			for (int p = 0; p < NPILE; p++) begin
				for (int i = 0; i <= MAXL; i++) phaso[p][i] = '0;
				for (int i = 0; i <= 2*MAXL; i++) disto[p][i] = '0;
			end
			for (int i = 0; i < MAXL; i++) begin
				fwd_hist[i] = '0;
				rev_hist[i] = '0;
			end
			head = '0;
			answers.delete();
			fail_count = 0;
			results_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LAG_WINDOW: win_reg <= cfg_data;
					REG_PEAK_LOW: plow_reg <= cfg_data;
					REG_PEAK_HIGH: phigh_reg <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (answers.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = answers.pop_front();
					if (read_value !== want.value)
						report_mismatch($sformatf("read_value %0d, expected %0d",
							read_value, want.value));
					if (status !== want.st)
						report_mismatch($sformatf("status %0b, expected %0b",
							status, want.st));
				end
			end
			if (in_valid && !in_stall) begin
				answers.insert(answers.size(), predict_beat());
				if (opcode == OP_SAMPLE) add_position(fwd_count, rev_count);
			end
		end
	end

endmodule

/* tb/tb_thresholded_lag_histogram_top.sv */
// Stimulus and verdict for the thresholded lag histogram block.
// Depends on tlh_pkg, thresholded_lag_histogram_top and the checker module.
module tb_thresholded_lag_histogram_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tlh_pkg::*;

	localparam int STALL_LIMIT = 30000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPCODE_W-1:0] opcode = OP_SAMPLE;
	logic [COUNT_W-1:0] fwd_count = '0;
	logic [COUNT_W-1:0] rev_count = '0;
	logic plot_select = 1'b0;
	logic [PILE_W-1:0] pile_index = '0;
	logic signed [LAG_W-1:0] lag = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [30:0] read_value;
	logic status;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LAG_WINDOW;
	logic [CFG_W-1:0] cfg_data = '0;

	int fail_count, pending, results_checked;
	int settings_run = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit quiet = 1'b0;
	int cur_win = 3000;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	thresholded_lag_histogram_top dut (.*);

	tb_thresholded_lag_histogram_checker chk (.*);

	// result side back-pressure in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			out_stall <= ($urandom_range(0, 3) == 0);
			stall_left = $urandom_range(1, 14);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_beat(input logic [1:0] op, input logic [15:0] f,
			input logic [15:0] r, input logic ps, input logic [3:0] pl,
			input logic [13:0] lg);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		fwd_count <= f;
		rev_count <= r;
		plot_select <= ps;
		pile_index <= pl;
		lag <= lg;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input int w, input int lo, input int hi);
		drain();
		write_reg(REG_LAG_WINDOW, w);
		write_reg(REG_PEAK_LOW, lo);
		write_reg(REG_PEAK_HIGH, hi);
		@(posedge clk);
		cur_win = (w > 4096) ? 4096 : w;
		settings_run++;
	endtask

	function automatic logic [15:0] some_count();
		return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
	endfunction

	task automatic random_beats(input int n, input int max_samples);
		int sel, samples, lg;
		logic [3:0] pl;
		samples = 0;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			pl = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 10));
			if ($urandom_range(0, 9) == 0)
				lg = int'($signed(14'($urandom)));
			else
				lg = $urandom_range(0, 2*cur_win + 4) - cur_win - 2;
			if (sel < 50 && samples < max_samples) begin
				samples++;
				send_beat(OP_SAMPLE, some_count(), some_count(), 1'($urandom), pl, 14'(lg));
			end else if (sel < 85) begin
				send_beat(OP_READ_BIN, 16'($urandom), 16'($urandom), 1'($urandom), pl,
					14'(lg));
			end else if (sel < 96) begin
				send_beat(OP_READ_PEAK, 16'($urandom), 16'($urandom), 1'($urandom), pl,
					14'(lg));
			end else begin
				send_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom), pl,
					14'(lg));
			end
		end
	endtask

	initial begin
		int w, lo, hi;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed beats at the reset settings
		send_beat(OP_SAMPLE, 16'd0, 16'd0, 1'b0, 4'd1, 14'd0);
		send_beat(OP_SAMPLE, 16'd1, 16'd10, 1'b0, 4'd1, 14'd0);
		send_beat(OP_SAMPLE, 16'hFFFF, 16'd5, 1'b1, 4'd15, 14'h3FFF);
		send_beat(OP_SAMPLE, 16'd11, 16'hFFFF, 1'b0, 4'd10, 14'd0);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd1, 14'd0);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd1, 14'd1);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd10, 14'd3000);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd1, 14'd3001);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd1, -14'sd1);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd1, -14'sd3000);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd5, -14'sd1);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd1, 14'd1);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd1, 14'd3001);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd2, 14'h2000);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b1, 4'd2, 14'd8191);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd0, 14'd0);
		send_beat(OP_READ_BIN, 16'd0, 16'd0, 1'b0, 4'd11, 14'd0);
		send_beat(OP_READ_PEAK, 16'd0, 16'd0, 1'b0, 4'd1, 14'd0);
		send_beat(OP_READ_PEAK, 16'd0, 16'd0, 1'b0, 4'd15, 14'd0);
		send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 4'd15, 14'h3FFF);
		// extremes of the registers
		set_regs(0, 0, 1);
		random_beats(14, 8);
		set_regs(8191, 8191, 8191);
		random_beats(8, 2);
		set_regs(4096, 0, 4096);
		random_beats(10, 3);
		set_regs(1, 1, 2);
		random_beats(14, 8);
		set_regs(16, 0, 0);
		random_beats(8, 4);
		for (int ph = 0; ph < 7; ph++) begin
			w = $urandom_range(1, 48);
			lo = $urandom_range(0, w);
			hi = $urandom_range(lo + 1, w + 1);
			if ($urandom_range(0, 4) == 0) hi = w + 2;
			if (ph == 6) quiet = 1'b1;
			set_regs(w, lo, hi);
			random_beats(17, 12);
		end
		drain();
		$display("Checked %0d results over %0d register settings", results_checked,
			settings_run);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/tlh_pkg.sv
rtl/tlh_sat_update.sv
rtl/thresholded_lag_histogram_top.sv
rtl/tlh_checker.sv
tb/tb_thresholded_lag_histogram_checker.sv
tb/tb_thresholded_lag_histogram_top.sv
